// ===== design/iri_pkg.sv =====
// iri_pkg: shared types and constants of the interval reservation table
// holds opcode and status codes, controller states and the cell control word
// no dependencies
package iri_pkg;

    localparam int TIME_W      = 17;
    localparam int IDX_W       = 5;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;

    localparam logic [TIME_W-1:0] LAST_SECOND = TIME_W'(86399);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              eval;
        logic              add_go;
        logic              rem_go;
        logic [TIME_W-1:0] start_second;
        logic [TIME_W-1:0] stop_second;
    } cell_ctrl_t;

endpackage

// ===== design/iri_cell.sv =====
// iri_cell: one entry of the interval table with its compare flags
// takes neighbor entries for insert and delete shifts
// depends on iri_pkg
module iri_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  iri_pkg::cell_ctrl_t        ctrl,
    input  logic                       valid,
    input  logic                       rem_ge,
    input  logic                       left_fs,
    input  logic [iri_pkg::TIME_W-1:0] left_start,
    input  logic [iri_pkg::TIME_W-1:0] left_stop,
    input  logic                       right_fs,
    input  logic [iri_pkg::TIME_W-1:0] right_start,
    input  logic [iri_pkg::TIME_W-1:0] right_stop,
    output logic [iri_pkg::TIME_W-1:0] start,
    output logic [iri_pkg::TIME_W-1:0] stop,
    output logic                       fs,
    output logic                       bad
);
    import iri_pkg::*;

    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] stop_reg;
    logic              fs_reg;
    logic              fe_reg;
    logic              pb_reg;
    logic              sa_reg;
    logic              ins_here;
    logic              shift_in;

    // compare flags, captured in the evaluate cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= 1'b0;
            fe_reg <= 1'b0;
            pb_reg <= 1'b0;
            sa_reg <= 1'b0;
        end
        else if (ctrl.eval)
        begin
            fs_reg <= valid & (start_reg <= ctrl.start_second);
            fe_reg <= valid & (stop_reg <= ctrl.stop_second);
            pb_reg <= ctrl.start_second <= stop_reg;
            sa_reg <= ctrl.stop_second >= start_reg;
        end
    end

    // slot position: first cell that is empty or whose begin is above the new begin
    assign ins_here = !fs_reg & left_fs;
    assign shift_in = !fs_reg & !left_fs;

    // mismatched counts, touching predecessor, touching successor
    assign bad = (fs_reg ^ fe_reg)
               | (fs_reg & !right_fs & pb_reg)
               | (valid & !fs_reg & left_fs & sa_reg);

    // entry data, shifted up on insert and down on delete
    always_ff @(posedge clk)
    begin
        if (ctrl.add_go)
        begin
            if (ins_here)
            begin
                start_reg <= ctrl.start_second;
                stop_reg  <= ctrl.stop_second;
            end
            else if (shift_in)
            begin
                start_reg <= left_start;
                stop_reg  <= left_stop;
            end
        end
        else if (ctrl.rem_go && rem_ge)
        begin
            start_reg <= right_start;
            stop_reg  <= right_stop;
        end
    end

    assign start = start_reg;
    assign stop  = stop_reg;
    assign fs    = fs_reg;

endmodule

// ===== design/interval_reservation_table_unit.sv =====
// interval_reservation_table_unit: top level of the interval reservation table
// holds the controller, count, output register and a chain of iri_cell
// depends on iri_pkg and iri_cell
//
// Usage: one input channel (in_valid / in_stall) carries an operation word:
// opcode, start_second, stop_second, slot_index. One output channel
// (out_valid / out_stall) returns one result word per operation: status,
// entry_count, read_start, read_stop.
// Each operation passes through an evaluate step and an apply step: in the first every cell compares its
// entry with the new interval and registers its flags, in the second the
// flags are combined, the decision is made and the chain shifts in one step.
// The result is loaded into the output register by the apply step, and a new
// word is accepted on the same edge; no word is accepted while one is in the
// evaluate step, a limit set by the registered compare stage ahead of the shift.
// When out_stall holds a waiting result, the block finishes evaluating the
// next word and then holds in_stall high until the output register frees.
// Reset empties the table (count zero) and clears the output valid flag;
// entries are not cleared and are never read before written.
module interval_reservation_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [iri_pkg::OP_W-1:0]     opcode,
    input  logic [iri_pkg::TIME_W-1:0]   start_second,
    input  logic [iri_pkg::TIME_W-1:0]   stop_second,
    input  logic [iri_pkg::IDX_W-1:0]    slot_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [iri_pkg::STATUS_W-1:0] status,
    output logic [iri_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic [iri_pkg::TIME_W-1:0]   read_start,
    output logic [iri_pkg::TIME_W-1:0]   read_stop
);
    import iri_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    state_t state_reg;
    state_t state_next;

    logic [OP_W-1:0]   op_reg;
    logic [TIME_W-1:0] b_reg;
    logic [TIME_W-1:0] e_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic [TIME_W-1:0]      rs_reg;
    logic [TIME_W-1:0]      re_reg;

    logic                in_accept;
    logic                out_take;
    logic                apply_go;
    logic                add_go;
    logic                rem_go;
    logic                bad_any;
    logic                time_bad;
    logic                idx_out;
    logic [STATUS_W-1:0] status_next;
    logic [TIME_W-1:0]   rs_next;
    logic [TIME_W-1:0]   re_next;
    logic [TIME_W-1:0]   rd_start;
    logic [TIME_W-1:0]   rd_stop;
    logic [CMP_W-1:0]    idx_cmp;
    cell_ctrl_t          ctrl;

    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] rem_ge_vec;
    logic [TABLE_DEPTH-1:0] fs_vec;
    logic [TABLE_DEPTH-1:0] bad_vec;
    logic [TIME_W-1:0]      cell_start [TABLE_DEPTH];
    logic [TIME_W-1:0]      cell_stop  [TABLE_DEPTH];

    // handshakes
    assign out_take  = out_valid_reg & !out_stall;
    assign apply_go  = (state_reg == S_APPLY) & (!out_valid_reg | !out_stall);
    assign in_stall  = !((state_reg == S_IDLE) | apply_go);
    assign in_accept = in_valid & !in_stall;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_EVAL;
            S_EVAL:  state_next = S_APPLY;
            S_APPLY:
            begin
                if (in_accept)
                    state_next = S_EVAL;
                else if (apply_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // operation word latch
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= opcode;
            b_reg   <= start_second;
            e_reg   <= stop_second;
            idx_reg <= slot_index;
        end
    end

    // per-cell valid and delete range: cells at and above the index pull down
    assign idx_cmp = CMP_W'(idx_reg);
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            valid_vec[i]  = CNT_W'(i) < count_reg;
            rem_ge_vec[i] = CMP_W'(i) >= idx_cmp;
        end
    end

    // read select over the cells
    always_comb
    begin
        rd_start = '0;
        rd_stop  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (idx_cmp == CMP_W'(i))
            begin
                rd_start = rd_start | cell_start[i];
                rd_stop  = rd_stop | cell_stop[i];
            end
        end
    end

    // decision
    assign bad_any  = |bad_vec;
    assign time_bad = (b_reg > LAST_SECOND) | (e_reg > LAST_SECOND) | (b_reg >= e_reg);
    assign idx_out  = idx_cmp >= CMP_W'(count_reg);

    always_comb
    begin
        status_next = ST_OK;
        rs_next     = '0;
        re_next     = '0;
        count_next  = count_reg;
        unique case (op_reg)
            OP_ADD:
            begin
                priority if (count_reg == DEPTH_C)
                    status_next = ST_FULL;
                else if (time_bad || bad_any)
                    status_next = ST_BAD;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            OP_REMOVE:
            begin
                if (idx_out)
                    status_next = ST_RANGE;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            OP_READ:
            begin
                if (idx_out)
                    status_next = ST_RANGE;
                else
                begin
                    rs_next = rd_start;
                    re_next = rd_stop;
                end
            end
            OP_NOP: status_next = ST_OK;
            default: status_next = ST_OK;
        endcase
    end

    assign add_go = apply_go & (op_reg == OP_ADD) & (status_next == ST_OK);
    assign rem_go = apply_go & (op_reg == OP_REMOVE) & (status_next == ST_OK);

    // count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (apply_go)
                count_reg <= count_next;
            if (apply_go)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            status_reg    <= status_next;
            count_out_reg <= COUNT_OUT_W'(count_next);
            rs_reg        <= rs_next;
            re_reg        <= re_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign read_start  = rs_reg;
    assign read_stop   = re_reg;

    // broadcast control word
    assign ctrl.eval         = (state_reg == S_EVAL);
    assign ctrl.add_go       = add_go;
    assign ctrl.rem_go       = rem_go;
    assign ctrl.start_second = b_reg;
    assign ctrl.stop_second  = e_reg;

    // chain of cells
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic              left_fs;
        logic [TIME_W-1:0] left_start;
        logic [TIME_W-1:0] left_stop;
        logic              right_fs;
        logic [TIME_W-1:0] right_start;
        logic [TIME_W-1:0] right_stop;

        if (g == 0)
        begin : g_first
            assign left_fs    = 1'b1;
            assign left_start = '0;
            assign left_stop  = '0;
        end
        else
        begin : g_inner_left
            assign left_fs    = fs_vec[g-1];
            assign left_start = cell_start[g-1];
            assign left_stop  = cell_stop[g-1];
        end

        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign right_fs    = 1'b0;
            assign right_start = '0;
            assign right_stop  = '0;
        end
        else
        begin : g_inner_right
            assign right_fs    = fs_vec[g+1];
            assign right_start = cell_start[g+1];
            assign right_stop  = cell_stop[g+1];
        end

        iri_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .valid       (valid_vec[g]),
            .rem_ge      (rem_ge_vec[g]),
            .left_fs     (left_fs),
            .left_start  (left_start),
            .left_stop   (left_stop),
            .right_fs    (right_fs),
            .right_start (right_start),
            .right_stop  (right_stop),
            .start       (cell_start[g]),
            .stop        (cell_stop[g]),
            .fs          (fs_vec[g]),
            .bad         (bad_vec[g])
        );
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_EVAL)
        else $error("accepted word not evaluated next cycle");

    a_eval_apply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |=> state_reg == S_APPLY)
        else $error("evaluate not followed by apply");

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        add_go |-> count_reg != DEPTH_C)
        else $error("insert into a full table");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        apply_go |=> out_valid_reg)
        else $error("finished operation left no result");

endmodule
